FILE: hw/rtl/swnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnf_pkg
// Shared widths, register indexes, reset values and command codes of the scan window search.
// ----------------------------------------------------------------------------
package swnf_pkg;

  localparam int RANGE_W   = 16;
  localparam int ANGLE_W   = 15;
  localparam int STEP_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_READINGS_DEF = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM  = 2'd2;

  // reset values
  localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST  = 15'h4DBC;   // -12868
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST = 12'd18;
  localparam logic [RANGE_W-1:0] RANGE_LIM_RST  = 16'd10000;

  localparam logic [RANGE_W-1:0] RANGE_NONE = 16'hFFFF;

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage : swnf_pkg
`default_nettype wire

FILE: hw/rtl/swnf_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnf_store
// Range reading memory: clamps and writes one reading, registered read port.
// ----------------------------------------------------------------------------
module swnf_store
  import swnf_pkg::*;
#(
  parameter int DEPTH  = MAX_READINGS_DEF,
  parameter int ADDR_W = $clog2(MAX_READINGS_DEF)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [RANGE_W-1:0] wr_sample,
  input  wire logic [RANGE_W-1:0] range_limit,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [RANGE_W-1:0] rd_data
);

  logic [RANGE_W-1:0] mem [DEPTH];
  logic [RANGE_W-1:0] clamped;

  // clamp to the configured maximum range
  assign clamped = (wr_sample > range_limit) ? range_limit : wr_sample;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= clamped;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : swnf_store
`default_nettype wire

FILE: hw/rtl/scan_window_nearest_furthest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scan_window_nearest_furthest
// Nearest and furthest reading of a stored laser scan over an angular window.
// ----------------------------------------------------------------------------
// Load words (command 0) write the next reading of the scan, clamped to
// range_limit; scan_start restarts the scan at reading zero, and a load
// beyond MAX_READINGS readings without scan_start is dropped. A
// query word (command 1) walks the stored readings through the single read
// port of the scan memory, one reading per cycle, with one comparator pair
// updating the nearest and furthest candidates. A query holds the input
// stalled for the whole walk, and further while an earlier result still
// waits untaken at the end of the walk, and then presents one
// result word, which waits in the output register until taken. The window
// holds readings whose angle a = scan_angle_min + i * scan_angle_step
// satisfies window_start - step <= a < window_end; reported angles are the
// reading angle plus half a step (rounded down), saturated to the 15-bit
// range. Ties go to the earliest reading. An empty scan or window returns
// nearest_range 65535, furthest_range 0, zero angles and window_empty set.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module scan_window_nearest_furthest
  import swnf_pkg::*;
#(
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic                 in_scan_start,
  input  wire logic [RANGE_W-1:0]   in_range_sample,
  input  wire logic [ANGLE_W-1:0]   in_window_start,
  input  wire logic [ANGLE_W-1:0]   in_window_end,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [RANGE_W-1:0]   out_nearest_range,
  output logic      [ANGLE_W-1:0]   out_nearest_angle,
  output logic      [RANGE_W-1:0]   out_furthest_range,
  output logic      [ANGLE_W-1:0]   out_furthest_angle,
  output logic                      out_window_empty,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RANGE_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MAX_READINGS);
  localparam int CNT_W  = $clog2(MAX_READINGS + 1);
  // wide enough for min angle + (MAX_READINGS-1) * step + half step
  localparam int ANG_W  = ADDR_W + STEP_W + 3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // ---------------------------------------------------------------- config
  logic [ANGLE_W-1:0] angle_min_r;
  logic [STEP_W-1:0]  angle_step_r;
  logic [RANGE_W-1:0] range_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r  <= ANGLE_MIN_RST;
      angle_step_r <= ANGLE_STEP_RST;
      range_lim_r  <= RANGE_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANGLE_MIN:  angle_min_r  <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_STEP: angle_step_r <= cfg_data[STEP_W-1:0];
        REG_RANGE_LIM:  range_lim_r  <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // sign/zero extended views of the configuration
  logic signed [ANG_W-1:0] amin_ext;
  logic signed [ANG_W-1:0] step_ext;
  logic signed [ANG_W-1:0] half_ext;

  assign amin_ext = ANG_W'($signed(angle_min_r));
  assign step_ext = $signed({{(ANG_W-STEP_W){1'b0}}, angle_step_r});
  assign half_ext = $signed({{(ANG_W-STEP_W+1){1'b0}}, angle_step_r[STEP_W-1:1]});

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [ANG_W-1:0] ang_r, ang_nxt;     // angle of reading idx_r
  logic signed [ANG_W-1:0] lo_r, hi_r;         // window bounds of the query

  // one reading in flight between memory read and tracker update
  logic                    pend_valid_r, pend_valid_nxt;
  logic                    pend_inwin_r;
  logic signed [ANG_W-1:0] pend_ang_r;         // reading angle + half step

  logic                    found_r, found_nxt;
  logic [RANGE_W-1:0]      near_r, near_nxt, far_r, far_nxt;
  logic signed [ANG_W-1:0] near_a_r, near_a_nxt, far_a_r, far_a_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [RANGE_W-1:0] out_near_r, out_far_r;
  logic [ANGLE_W-1:0] out_near_a_r, out_far_a_r;
  logic               out_empty_r;

  logic               in_acc;
  logic               load_acc;
  logic               query_acc;
  logic               issue;
  logic               out_load;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [RANGE_W-1:0] rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_command == CMD_LOAD);
  assign query_acc = in_acc && (in_command == CMD_QUERY);

  // write at the fill position; a full store drops loads until a new scan
  assign wr_en   = load_acc && (in_scan_start || (count_r < CNT_W'(MAX_READINGS)));
  assign wr_addr = in_scan_start ? '0 : count_r[ADDR_W-1:0];

  // issue one read per cycle while readings remain
  assign issue    = (state_r == ST_SCAN) && (idx_r < count_r);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  swnf_store #(
    .DEPTH  (MAX_READINGS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_sample   (in_range_sample),
    .range_limit (range_lim_r),
    .rd_en       (issue),
    .rd_addr     (idx_r[ADDR_W-1:0]),
    .rd_data     (rd_data)
  );

  // saturate a wide angle to the 15-bit signed output range
  function automatic logic [ANGLE_W-1:0] pack_angle(input logic signed [ANG_W-1:0] a);
    logic in_range;
    in_range = (a[ANG_W-1:ANGLE_W-1] == '0) || (a[ANG_W-1:ANGLE_W-1] == '1);
    if (in_range) begin
      pack_angle = a[ANGLE_W-1:0];
    end else if (a[ANG_W-1]) begin
      pack_angle = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      pack_angle = {1'b0, {(ANGLE_W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ang_nxt        = ang_r;
    pend_valid_nxt = issue;
    found_nxt      = found_r;
    near_nxt       = near_r;
    near_a_nxt     = near_a_r;
    far_nxt        = far_r;
    far_a_nxt      = far_a_r;
    out_valid_nxt  = out_valid_r;

    // advance the fill count on every stored reading; scan_start restarts it at one
    if (wr_en) begin
      count_nxt = in_scan_start ? CNT_W'(1) : count_r + CNT_W'(1);
    end

    // shared compare unit: fold the reading read last cycle into the trackers
    if (pend_valid_r && pend_inwin_r) begin
      found_nxt = 1'b1;
      if (!found_r || (rd_data < near_r)) begin
        near_nxt   = rd_data;
        near_a_nxt = pend_ang_r;
      end
      if (!found_r || (rd_data > far_r)) begin
        far_nxt   = rd_data;
        far_a_nxt = pend_ang_r;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          idx_nxt   = '0;
          ang_nxt   = amin_ext;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
          ang_nxt = ang_r + step_ext;
        end else begin
          // last read is folded in at this edge
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ang_r    <= ang_nxt;
    near_r   <= near_nxt;
    near_a_r <= near_a_nxt;
    far_r    <= far_nxt;
    far_a_r  <= far_a_nxt;
    // capture the window bounds with the query
    if (query_acc) begin
      lo_r <= ANG_W'($signed(in_window_start)) - step_ext;
      hi_r <= ANG_W'($signed(in_window_end));
    end
    if (issue) begin
      pend_inwin_r <= (ang_r >= lo_r) && (ang_r < hi_r);
      pend_ang_r   <= ang_r + half_ext;
    end
    if (out_load) begin
      if (found_r) begin
        out_near_r   <= near_r;
        out_near_a_r <= pack_angle(near_a_r);
        out_far_r    <= far_r;
        out_far_a_r  <= pack_angle(far_a_r);
        out_empty_r  <= 1'b0;
      end else begin
        out_near_r   <= RANGE_NONE;
        out_near_a_r <= '0;
        out_far_r    <= '0;
        out_far_a_r  <= '0;
        out_empty_r  <= 1'b1;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_nearest_range  = out_near_r;
  assign out_nearest_angle  = out_near_a_r;
  assign out_furthest_range = out_far_r;
  assign out_furthest_angle = out_far_a_r;
  assign out_window_empty   = out_empty_r;

endmodule : scan_window_nearest_furthest
`default_nettype wire
